### rtl/core/cht_pkg.sv
package cht_pkg;

  localparam int TABLE_SLOTS_DEF = 2048;
  localparam int WORD_W = 116;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
  localparam logic [63:0] FNV_MULT = 64'h00000100000001B3;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam logic [33:0] POW10 [10] = '{
    34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000, 34'd1000000,
    34'd10000000, 34'd100000000, 34'd1000000000
  };

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_BAD_VAL = 2'd2,
    STAT_FULL    = 2'd3
  } stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HSTART,
    ST_HWAIT,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_RM_RD,
    ST_RM_CHK,
    ST_RM_HSTART,
    ST_RM_HWAIT,
    ST_RM_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] cli_addr;
    logic [31:0] srv_addr;
    logic [15:0] cli_port;
    logic [15:0] srv_port;
    logic [7:0]  protocol;
    logic [11:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] found_value;
    logic [10:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic  clr_step;
    logic  load_item;
    logic  hash_start;
    logic  hash_slot;
    logic  set_home;
    logic  rd_probe;
    logic  probe_next;
    logic  ins_write;
    logic  rm_init;
    logic  rd_j;
    logic  latch;
    logic  rm_shift;
    logic  rm_step;
    logic  rm_clear;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  set_status;
    stat_t status;
    logic  set_found;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic clr_last;
    logic hash_done;
    logic slot_free;
    logic slot_match;
    logic n_full;
    logic val_bad;
    logic tbl_full;
    logic shift_ok;
    logic out_busy;
    op_t  op;
  } sts_t;

endpackage

### rtl/core/cht_if.sv
interface cht_in_if;
  logic              valid;
  logic              ready;
  cht_pkg::in_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface cht_out_if;
  logic               valid;
  logic               ready;
  cht_pkg::out_item_t item;

  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

### rtl/core/cht_ram.sv
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/core/cht_hash.sv
module cht_hash #(
  parameter int SLOT_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [31:0]       cip,
  input  logic [31:0]       sip,
  input  logic [15:0]       cport,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);
  import cht_pkg::*;

  localparam logic [SLOT_W-1:0] BASIS = FNV_BASIS[SLOT_W-1:0];
  localparam logic [SLOT_W-1:0] PRIME_LO = FNV_MULT[SLOT_W-1:0];

  logic              busy_r;
  logic              done_r;
  logic [1:0]        fld_r;
  logic              sgn_r;
  logic [3:0]        pos_r;
  logic [31:0]       mag_r;
  logic              started_r;
  logic [SLOT_W-1:0] h_r;
  logic [31:0]       sip_r;
  logic [15:0]       cport_r;

  logic [33:0]         thr [10];
  logic [3:0]          dsel;
  logic [33:0]         sub;
  logic                emit;
  logic [7:0]          ch;
  logic [63:0]         h64;
  logic [SLOT_W-1:0]   hx;
  logic [2*SLOT_W-1:0] prod;

  always_comb begin
    for (int d = 0; d < 10; d++) begin
      thr[d] = POW10[pos_r] * 34'(d);
    end
    dsel = '0;
    for (int d = 1; d < 10; d++) begin
      if ({2'b00, mag_r} >= thr[d]) begin
        dsel = 4'(d);
      end
    end
    sub = thr[dsel];
    emit = sgn_r || (dsel != 4'd0) || started_r || (pos_r == 4'd0);
    ch = sgn_r ? CH_MINUS : (CH_ZERO + {4'b0000, dsel});
    h64 = {{(64-SLOT_W){1'b0}}, h_r} ^ {56'b0, ch};
    hx = h64[SLOT_W-1:0];
    prod = hx * PRIME_LO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && !sgn_r && (pos_r == 4'd0) && (fld_r == 2'd2);
      if (start) begin
        busy_r <= 1'b1;
        h_r <= BASIS;
        fld_r <= 2'd0;
        sgn_r <= cip[31];
        mag_r <= cip[31] ? (~cip + 32'd1) : cip;
        pos_r <= 4'd9;
        started_r <= 1'b0;
        sip_r <= sip;
        cport_r <= cport;
      end else if (busy_r) begin
        if (emit) begin
          h_r <= prod[SLOT_W-1:0];
        end
        if (sgn_r) begin
          sgn_r <= 1'b0;
        end else if (pos_r != 4'd0) begin
          started_r <= started_r | emit;
          mag_r <= mag_r - sub[31:0];
          pos_r <= pos_r - 4'd1;
        end else begin
          pos_r <= 4'd9;
          started_r <= 1'b0;
          fld_r <= fld_r + 2'd1;
          case (fld_r)
            2'd0: begin
              sgn_r <= sip_r[31];
              mag_r <= sip_r[31] ? (~sip_r + 32'd1) : sip_r;
            end
            2'd1: begin
              sgn_r <= 1'b0;
              mag_r <= {16'b0, cport_r};
            end
            default: begin
              busy_r <= 1'b0;
            end
          endcase
        end
      end
    end
  end

  assign done = done_r;
  assign slot = h_r;
endmodule

### rtl/core/cht_dp.sv
module cht_dp #(
  parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cht_pkg::cmd_t      cmd,
  output cht_pkg::sts_t      sts,
  input  logic               in_valid,
  input  cht_pkg::in_item_t  in_item,
  input  logic               out_ready,
  output logic               out_valid,
  output cht_pkg::out_item_t out_item
);
  import cht_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int N_W = SLOT_W + 1;

  in_item_t          item_r;
  logic [SLOT_W-1:0] clr_r;
  logic [SLOT_W-1:0] s_r;
  logic [SLOT_W-1:0] gap_r;
  logic [SLOT_W-1:0] j_r;
  logic [N_W-1:0]    n_r;
  logic [SLOT_W-1:0] cnt_r;
  logic [WORD_W-1:0] slot_r;
  stat_t             status_r;
  logic [11:0]       found_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic              re;
  logic [SLOT_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;
  logic              h_done;
  logic [SLOT_W-1:0] h_slot;
  logic [31:0]       h_cip;
  logic [31:0]       h_sip;
  logic [15:0]       h_cport;
  logic [SLOT_W-1:0] dist_k;
  logic [SLOT_W-1:0] dist_g;

  cht_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  assign h_cip = cmd.hash_slot ? slot_r[115:84] : item_r.cli_addr;
  assign h_sip = cmd.hash_slot ? slot_r[83:52] : item_r.srv_addr;
  assign h_cport = cmd.hash_slot ? slot_r[51:36] : item_r.cli_port;

  cht_hash #(.SLOT_W(SLOT_W)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(cmd.hash_start),
    .cip(h_cip), .sip(h_sip), .cport(h_cport),
    .done(h_done), .slot(h_slot)
  );

  always_comb begin
    we = 1'b0;
    waddr = gap_r;
    wdata = '0;
    if (cmd.clr_step) begin
      we = 1'b1;
      waddr = clr_r;
    end else if (cmd.ins_write) begin
      we = 1'b1;
      waddr = s_r;
      wdata = {item_r.cli_addr, item_r.srv_addr, item_r.cli_port,
               item_r.srv_port, item_r.protocol, item_r.entry_value};
    end else if (cmd.rm_shift) begin
      we = 1'b1;
      wdata = slot_r;
    end else if (cmd.rm_clear) begin
      we = 1'b1;
    end
    re = cmd.rd_probe | cmd.rd_j;
    raddr = cmd.rd_j ? (j_r + SLOT_W'(1)) : s_r;
  end

  assign dist_k = j_r - h_slot;
  assign dist_g = j_r - gap_r;

  always_comb begin
    sts.in_valid = in_valid;
    sts.clr_last = (clr_r == '1);
    sts.hash_done = h_done;
    sts.slot_free = (rdata[11:0] == 12'd0);
    sts.slot_match = (rdata[115:52] == {item_r.cli_addr, item_r.srv_addr}) &&
                     (rdata[51:12] == {item_r.cli_port, item_r.srv_port,
                                       item_r.protocol});
    sts.n_full = (n_r == N_W'(TABLE_SLOTS));
    sts.val_bad = (item_r.entry_value == 12'd0) ||
                  ({5'b0, item_r.entry_value} > 17'(TABLE_SLOTS));
    sts.tbl_full = (cnt_r >= SLOT_W'(TABLE_SLOTS / 2));
    sts.shift_ok = (dist_k >= dist_g);
    sts.out_busy = out_valid_r & ~out_ready;
    sts.op = op_t'(item_r.operation);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + SLOT_W'(1);
      end else if (cmd.cnt_dec && cnt_r != '0) begin
        cnt_r <= cnt_r - SLOT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
      status_r <= STAT_MISS;
      found_r <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.set_found) begin
      found_r <= rdata[11:0];
    end
    if (cmd.set_home) begin
      s_r <= h_slot;
      n_r <= '0;
    end else if (cmd.probe_next) begin
      s_r <= s_r + SLOT_W'(1);
      n_r <= n_r + N_W'(1);
    end else if (cmd.rm_init) begin
      gap_r <= s_r;
      j_r <= s_r;
      n_r <= '0;
    end else begin
      if (cmd.rd_j) begin
        j_r <= j_r + SLOT_W'(1);
      end
      if (cmd.rm_step) begin
        n_r <= n_r + N_W'(1);
      end
      if (cmd.rm_shift) begin
        gap_r <= j_r;
      end
    end
    if (cmd.latch) begin
      slot_r <= rdata;
    end
    if (cmd.out_load) begin
      out_r.status <= status_r;
      out_r.found_value <= found_r;
      out_r.occupancy <= 11'(cnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;
endmodule

### rtl/core/cht_ctrl.sv
module cht_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  cht_pkg::sts_t sts,
  output cht_pkg::cmd_t cmd,
  output logic          in_ready
);
  import cht_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status = STAT_OK;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt = ST_HSTART;
        end
      end
      ST_HSTART: begin
        cmd.hash_start = 1'b1;
        state_nxt = ST_HWAIT;
      end
      ST_HWAIT: begin
        if (sts.hash_done) begin
          cmd.set_home = 1'b1;
          case (sts.op)
            OP_LOOKUP, OP_DELETE: state_nxt = ST_PRB_RD;
            OP_INSERT: begin
              if (sts.val_bad) begin
                cmd.set_status = 1'b1;
                cmd.status = STAT_BAD_VAL;
                state_nxt = ST_DONE;
              end else if (sts.tbl_full) begin
                cmd.set_status = 1'b1;
                cmd.status = STAT_FULL;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_PRB_RD;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_PRB_RD: begin
        cmd.rd_probe = 1'b1;
        state_nxt = ST_PRB_CHK;
      end
      ST_PRB_CHK: begin
        if (sts.slot_free || sts.n_full) begin
          if (sts.op == OP_INSERT) begin
            cmd.ins_write = 1'b1;
            cmd.cnt_inc = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status = STAT_OK;
          end
          state_nxt = ST_DONE;
        end else if (sts.slot_match && sts.op != OP_INSERT) begin
          if (sts.op == OP_LOOKUP) begin
            cmd.set_status = 1'b1;
            cmd.status = STAT_OK;
            cmd.set_found = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            cmd.rm_init = 1'b1;
            state_nxt = ST_RM_RD;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt = ST_PRB_RD;
        end
      end
      ST_RM_RD: begin
        if (sts.n_full) begin
          state_nxt = ST_RM_END;
        end else begin
          cmd.rd_j = 1'b1;
          state_nxt = ST_RM_CHK;
        end
      end
      ST_RM_CHK: begin
        cmd.latch = 1'b1;
        state_nxt = sts.slot_free ? ST_RM_END : ST_RM_HSTART;
      end
      ST_RM_HSTART: begin
        cmd.hash_start = 1'b1;
        cmd.hash_slot = 1'b1;
        state_nxt = ST_RM_HWAIT;
      end
      ST_RM_HWAIT: begin
        cmd.hash_slot = 1'b1;
        if (sts.hash_done) begin
          cmd.rm_shift = sts.shift_ok;
          cmd.rm_step = 1'b1;
          state_nxt = ST_RM_RD;
        end
      end
      ST_RM_END: begin
        cmd.rm_clear = 1'b1;
        cmd.cnt_dec = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status = STAT_OK;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

### rtl/core/connection_hash_table.sv
// Open-addressing connection table keyed by the five-tuple, one operation
// (lookup, insert, delete) at a time. After reset the slot memory is swept
// clear, one slot a cycle, so no item is taken until the sweep ends. An
// operation then takes the item, hashes the client address, server address
// and client port (one decimal digit or sign character a cycle through the
// FNV unit), reads and checks each slot probed on the single read port and
// loads the result; a delete also rehashes to find the home slot of every
// entry examined by the backward shift and then frees the last gap. The
// result sits in an output register, so the next item may enter while it
// waits to be taken.
module connection_hash_table #(
  parameter int TABLE_SLOTS = cht_pkg::TABLE_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cht_in_if.sink     in_ch,
  cht_out_if.source  out_ch
);
  import cht_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  cht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd), .in_ready(in_ready)
  );

  cht_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_valid(in_ch.valid), .in_item(in_ch.item),
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_item(out_ch.item)
  );
endmodule

### bench/connection_hash_table_tb.sv
`timescale 1ns / 100ps

module connection_hash_table_tb;
  import cht_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int MASK = SLOTS - 1;
  localparam int RANDOM_ITEMS = 300;
  localparam int POOL_MAX = 40;
  localparam int DRAIN_OPS = 150;

  class conn_table_scoreboard;
    logic [63:0] addr_mem [SLOTS];
    logic [39:0] key_mem [SLOTS];
    logic [11:0] val_mem [SLOTS];
    int unsigned entries;
    out_item_t expected_q [$];
    int errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        addr_mem[i] = '0;
        key_mem[i] = '0;
        val_mem[i] = '0;
      end
      entries = 0;
      errors = 0;
    endfunction

    function automatic logic [63:0] fnv_dec(logic [63:0] h, logic [31:0] mag, bit neg);
      logic [7:0] dig [10];
      int n;
      n = 0;
      if (neg) h = (h ^ {56'b0, CH_MINUS}) * FNV_MULT;
      do begin
        dig[n] = CH_ZERO + 8'(mag % 10);
        mag = mag / 10;
        n++;
      end while (mag != 0);
      for (int i = n - 1; i >= 0; i--) h = (h ^ {56'b0, dig[i]}) * FNV_MULT;
      return h;
    endfunction

    function automatic logic [63:0] fnv_signed(logic [63:0] h, logic [31:0] v);
      if (v[31]) return fnv_dec(h, -v, 1'b1);
      return fnv_dec(h, v, 1'b0);
    endfunction

    function automatic int home_of(logic [31:0] cip, logic [31:0] sip, logic [15:0] cport);
      logic [63:0] h;
      h = fnv_signed(FNV_BASIS, cip);
      h = fnv_signed(h, sip);
      h = fnv_dec(h, {16'b0, cport}, 1'b0);
      return int'(h & 64'(MASK));
    endfunction

    function automatic int find_entry(logic [63:0] a, logic [39:0] k, int s);
      for (int n = 0; n < SLOTS; n++) begin
        if (val_mem[s] == 0) break;
        if (addr_mem[s] == a && key_mem[s] == k) return s;
        s = (s + 1) & MASK;
      end
      return -1;
    endfunction

    function automatic void backshift(int gap);
      int j;
      int k;
      j = gap;
      for (int n = 0; n < SLOTS; n++) begin
        j = (j + 1) & MASK;
        if (val_mem[j] == 0) break;
        k = home_of(addr_mem[j][63:32], addr_mem[j][31:0], key_mem[j][39:24]);
        if (((j - k) & MASK) >= ((j - gap) & MASK)) begin
          addr_mem[gap] = addr_mem[j];
          key_mem[gap] = key_mem[j];
          val_mem[gap] = val_mem[j];
          gap = j;
        end
      end
      val_mem[gap] = '0;
    endfunction

    function automatic void note_input(in_item_t it);
      out_item_t r;
      logic [63:0] a;
      logic [39:0] k;
      int s;
      a = {it.cli_addr, it.srv_addr};
      k = {it.cli_port, it.srv_port, it.protocol};
      s = home_of(it.cli_addr, it.srv_addr, it.cli_port);
      r.status = STAT_MISS;
      r.found_value = '0;
      case (it.operation)
        OP_LOOKUP: begin
          s = find_entry(a, k, s);
          if (s >= 0) begin
            r.status = STAT_OK;
            r.found_value = val_mem[s];
          end
        end
        OP_INSERT: begin
          if (it.entry_value == 0 || it.entry_value > SLOTS) begin
            r.status = STAT_BAD_VAL;
          end else if (entries >= SLOTS / 2) begin
            r.status = STAT_FULL;
          end else begin
            for (int n = 0; n < SLOTS; n++) begin
              if (val_mem[s] == 0) break;
              s = (s + 1) & MASK;
            end
            addr_mem[s] = a;
            key_mem[s] = k;
            val_mem[s] = it.entry_value;
            entries++;
            r.status = STAT_OK;
          end
        end
        OP_DELETE: begin
          s = find_entry(a, k, s);
          if (s >= 0) begin
            backshift(s);
            if (entries > 0) entries--;
            r.status = STAT_OK;
          end
        end
        default: ;
      endcase
      r.occupancy = 11'(entries);
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item, status", got.status, -1);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.found_value !== want.found_value)
        report_mismatch("found_value", got.found_value, want.found_value);
      if (got.occupancy !== want.occupancy)
        report_mismatch("occupancy", got.occupancy, want.occupancy);
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit gaps_on;
  conn_table_scoreboard sb;
  in_item_t key_pool [$];
  in_item_t fill_keys [$];

  cht_in_if in_ch();
  cht_out_if out_ch();

  connection_hash_table u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #80_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.item);
      out_ch.ready <= gaps_on ? ($urandom_range(99) >= 34) : 1'b1;
    end
  end

  task automatic send_item(input in_item_t it);
    while (gaps_on && $urandom_range(99) < 34) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(it);
  endtask

  function automatic in_item_t rand_key();
    in_item_t k;
    k.operation = OP_LOOKUP;
    k.cli_addr = ($urandom_range(3) == 0) ? 32'($urandom_range(999)) : $urandom;
    k.srv_addr = ($urandom_range(3) == 0) ? -32'($urandom_range(999)) : $urandom;
    k.cli_port = 16'($urandom);
    k.srv_port = 16'($urandom);
    k.protocol = 8'($urandom);
    k.entry_value = 12'($urandom_range(1, SLOTS));
    return k;
  endfunction

  task automatic send_op(input in_item_t k, input logic [1:0] op, input logic [11:0] v);
    k.operation = op;
    k.entry_value = v;
    send_item(k);
  endtask

  initial begin
    in_item_t k;
    in_item_t d;
    int sel;
    sb = new();
    gaps_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.item = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // extremes of the key fields and values
    d = '0;
    send_op(d, OP_LOOKUP, 12'd0);
    send_op(d, OP_INSERT, 12'd1);
    send_op(d, OP_LOOKUP, 12'd0);
    d = '1;
    send_op(d, OP_INSERT, 12'(SLOTS));
    send_op(d, OP_LOOKUP, 12'hFFF);
    send_op(d, OP_INSERT, 12'd0);
    send_op(d, OP_INSERT, 12'(SLOTS + 1));
    send_op(d, OP_INSERT, 12'hFFF);
    d.cli_addr = 32'h8000_0000;
    d.srv_addr = 32'h7FFF_FFFF;
    send_op(d, OP_INSERT, 12'd77);
    send_op(d, OP_LOOKUP, 12'd0);
    // duplicate key
    send_op(d, OP_INSERT, 12'd78);
    send_op(d, OP_LOOKUP, 12'd0);
    send_op(d, OP_DELETE, 12'd0);
    send_op(d, OP_LOOKUP, 12'd0);
    send_op(d, OP_DELETE, 12'd0);
    send_op(d, OP_DELETE, 12'd0);
    send_op(d, OP_UNUSED, 12'd5);
    d = '0;
    d.srv_port = 16'hFFFF;
    send_op(d, OP_LOOKUP, 12'd0);
    send_op(d, OP_DELETE, 12'd0);
    d = '0;
    send_op(d, OP_DELETE, 12'd0);
    send_op(d, OP_LOOKUP, 12'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on = !(i >= 100 && i < 200);
      if (key_pool.size() == 0 || $urandom_range(4) == 0) begin
        k = rand_key();
        if (key_pool.size() < POOL_MAX) key_pool.push_back(k);
      end else begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      end
      sel = $urandom_range(99);
      if (sel < 38)
        send_op(k, OP_INSERT, ($urandom_range(9) == 0) ? 12'($urandom)
                                                       : 12'($urandom_range(1, SLOTS)));
      else if (sel < 68) send_op(k, OP_LOOKUP, 12'($urandom));
      else if (sel < 96) send_op(k, OP_DELETE, 12'($urandom));
      else send_op(k, OP_UNUSED, 12'($urandom));
    end

    // hold off until the table is quiet
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);

    // fill to the half-full limit, then drain part of it
    while (sb.entries < SLOTS / 2) begin
      k = rand_key();
      fill_keys.push_back(k);
      send_op(k, OP_INSERT, k.entry_value);
    end
    for (int i = 0; i < 4; i++) send_op(rand_key(), OP_INSERT, 12'($urandom_range(1, SLOTS)));
    for (int i = 0; i < 10; i++)
      send_op(fill_keys[$urandom_range(fill_keys.size() - 1)], OP_LOOKUP, 12'd0);
    fill_keys.shuffle();
    for (int i = 0; i < DRAIN_OPS && fill_keys.size() != 0; i++) begin
      k = fill_keys.pop_front();
      send_op(k, OP_DELETE, 12'd0);
      if ($urandom_range(7) == 0) send_op(k, OP_LOOKUP, 12'd0);
    end
    foreach (key_pool[idx]) send_op(key_pool[idx], OP_DELETE, 12'd0);

    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
